### hdl/blpg_pkg.sv
// Shared constants for the Bresenham line pixel generator.
`default_nettype none
package blpg_pkg;

  // Widths that do not vary with the coordinate size.
  localparam int SCREEN_BITS = 12;
  localparam int COLOR_BITS  = 24;

  // Command codes carried on the cmd field.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Configuration register indexes.
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Screen size after reset.
  localparam logic [SCREEN_BITS-1:0] RESET_WIDTH  = 12'd800;
  localparam logic [SCREEN_BITS-1:0] RESET_HEIGHT = 12'd600;

endpackage
`default_nettype wire

### hdl/bresenham_line_pixel_generator.sv
// Top level of the Bresenham line pixel generator.
`default_nettype none
// One command transaction is taken per clock cycle while cmd_stall is low. A start
// command loads the line and produces its first pixel; each step command produces
// the next pixel, or nothing once the line is finished. The pixel appears on the
// output register in the cycle after the command is taken, and a new command may
// be taken in every cycle while that register is free or being emptied. The rate of
// one pixel per cycle rests on the position and decision registers being updated
// once per pixel. cmd_stall is raised only while a pixel waits on a stalled output.
module bresenham_line_pixel_generator #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic                                  cfg_index,
  input  wire logic [blpg_pkg::SCREEN_BITS-1:0]      cfg_data,
  // Command channel
  input  wire logic                                  cmd_valid,
  output logic                                       cmd_stall,
  input  wire logic                                  cmd,
  input  wire logic signed [COORD_BITS-1:0]          start_x,
  input  wire logic signed [COORD_BITS-1:0]          start_y,
  input  wire logic signed [COORD_BITS-1:0]          end_x,
  input  wire logic signed [COORD_BITS-1:0]          end_y,
  input  wire logic [blpg_pkg::COLOR_BITS-1:0]       line_color,
  // Pixel channel
  output logic                                       pix_valid,
  input  wire logic                                  pix_stall,
  output logic signed [COORD_BITS-1:0]               pix_x,
  output logic signed [COORD_BITS-1:0]               pix_y,
  output logic [blpg_pkg::COLOR_BITS-1:0]            pix_color,
  output logic                                       visible,
  output logic                                       last
);

  localparam int AW = COORD_BITS + 1;  // coordinate difference and its magnitude
  localparam int DW = COORD_BITS + 3;  // decision term

  // Configuration registers.
  logic [blpg_pkg::SCREEN_BITS-1:0] screen_width;
  logic [blpg_pkg::SCREEN_BITS-1:0] screen_height;

  // Line state.
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] major_end;
  logic signed [DW-1:0]         decision;
  logic [AW-1:0]                abs_dx;
  logic [AW-1:0]                abs_dy;
  logic                         x_major;
  logic                         minor_up;
  logic [blpg_pkg::COLOR_BITS-1:0] held_color;
  logic                         active;

  // Next values.
  logic signed [COORD_BITS-1:0] cur_x_next;
  logic signed [COORD_BITS-1:0] cur_y_next;
  logic signed [COORD_BITS-1:0] major_end_next;
  logic signed [DW-1:0]         decision_next;
  logic [AW-1:0]                abs_dx_next;
  logic [AW-1:0]                abs_dy_next;
  logic                         x_major_next;
  logic                         minor_up_next;
  logic [blpg_pkg::COLOR_BITS-1:0] held_color_next;

  // Start command working values.
  logic signed [AW-1:0] dx;
  logic signed [AW-1:0] dy;
  logic [AW-1:0]        st_adx;
  logic [AW-1:0]        st_ady;
  logic                 st_xmajor;

  // Step working values.
  logic signed [DW-1:0] two_dx;
  logic signed [DW-1:0] two_dy;
  logic                 keep_minor;
  logic signed [COORD_BITS-1:0] minor_delta;

  // Handshake and emit.
  logic                 accept;
  logic                 produce;
  logic                 fin;
  logic                 vis;
  logic signed [COORD_BITS-1:0] major_pos;

  // A pixel is produced for every start, and for a step while a line is active.
  assign cmd_stall = pix_valid && pix_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign produce   = accept && ((cmd == blpg_pkg::CMD_START) || active);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= blpg_pkg::RESET_WIDTH;
      screen_height <= blpg_pkg::RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        blpg_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        blpg_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Set-up of a new line: deltas, magnitudes and the major axis.
  always_comb begin
    dx        = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    dy        = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};
    st_adx    = dx[AW-1] ? AW'(-dx) : AW'(dx);
    st_ady    = dy[AW-1] ? AW'(-dy) : AW'(dy);
    st_xmajor = st_ady <= st_adx;
  end

  // Doubled magnitudes held for the step updates.
  assign two_dx = $signed({1'b0, abs_dx, 1'b0});
  assign two_dy = $signed({1'b0, abs_dy, 1'b0});

  // The x-major test keeps the minor coordinate on a negative term, the
  // y-major test on a term that is zero or negative.
  assign keep_minor  = x_major ? decision[DW-1] : (decision[DW-1] || (decision == '0));
  assign minor_delta = minor_up ? COORD_BITS'(1) : {COORD_BITS{1'b1}};

  // Next line state for either command.
  always_comb begin
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    major_end_next  = major_end;
    decision_next   = decision;
    abs_dx_next     = abs_dx;
    abs_dy_next     = abs_dy;
    x_major_next    = x_major;
    minor_up_next   = minor_up;
    held_color_next = held_color;
    if (cmd == blpg_pkg::CMD_START) begin
      abs_dx_next     = st_adx;
      abs_dy_next     = st_ady;
      x_major_next    = st_xmajor;
      minor_up_next   = (dx[AW-1] && dy[AW-1]) ||
                        (!dx[AW-1] && (dx != '0) && !dy[AW-1] && (dy != '0));
      held_color_next = line_color;
      if (st_xmajor) begin
        decision_next = $signed({1'b0, st_ady, 1'b0}) - $signed({2'b00, st_adx});
        if (!dx[AW-1]) begin
          cur_x_next = start_x; cur_y_next = start_y; major_end_next = end_x;
        end else begin
          cur_x_next = end_x; cur_y_next = end_y; major_end_next = start_x;
        end
      end else begin
        decision_next = $signed({1'b0, st_adx, 1'b0}) - $signed({2'b00, st_ady});
        if (!dy[AW-1]) begin
          cur_x_next = start_x; cur_y_next = start_y; major_end_next = end_y;
        end else begin
          cur_x_next = end_x; cur_y_next = end_y; major_end_next = start_y;
        end
      end
    end else if (x_major) begin
      cur_x_next = cur_x + COORD_BITS'(1);
      if (keep_minor) begin
        decision_next = decision + two_dy;
      end else begin
        cur_y_next    = cur_y + minor_delta;
        decision_next = decision + (two_dy - two_dx);
      end
    end else begin
      cur_y_next = cur_y + COORD_BITS'(1);
      if (keep_minor) begin
        decision_next = decision + two_dx;
      end else begin
        cur_x_next    = cur_x + minor_delta;
        decision_next = decision + (two_dx - two_dy);
      end
    end
  end

  // Final-pixel and on-screen tests on the new position.
  assign major_pos = x_major_next ? cur_x_next : cur_y_next;
  assign fin       = major_pos >= major_end_next;
  assign vis       = !cur_x_next[COORD_BITS-1] && !cur_y_next[COORD_BITS-1] &&
                     ({{blpg_pkg::SCREEN_BITS{1'b0}}, cur_x_next} <
                      {{COORD_BITS{1'b0}}, screen_width}) &&
                     ({{blpg_pkg::SCREEN_BITS{1'b0}}, cur_y_next} <
                      {{COORD_BITS{1'b0}}, screen_height});

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      major_end  <= '0;
      decision   <= '0;
      abs_dx     <= '0;
      abs_dy     <= '0;
      x_major    <= 1'b0;
      minor_up   <= 1'b0;
      held_color <= '0;
      active     <= 1'b0;
    end else if (produce) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      major_end  <= major_end_next;
      decision   <= decision_next;
      abs_dx     <= abs_dx_next;
      abs_dy     <= abs_dy_next;
      x_major    <= x_major_next;
      minor_up   <= minor_up_next;
      held_color <= held_color_next;
      active     <= !fin;
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (produce) begin
      pix_valid <= 1'b1;
    end else if (!pix_stall) begin
      pix_valid <= 1'b0;
    end
  end

  // Output register: pixel payload.
  always_ff @(posedge clk) begin
    if (produce) begin
      pix_x     <= cur_x_next;
      pix_y     <= cur_y_next;
      pix_color <= held_color_next;
      visible   <= vis;
      last      <= fin;
    end
  end

`ifndef ASSERT_OFF
  // The command side is held back only by a waiting, stalled pixel.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> (pix_valid && pix_stall))
    else $error("command stalled without a stalled pixel");

  // Producing the final pixel ends the line.
  a_line_ends: assert property (@(posedge clk) disable iff (rst)
    (produce && fin) |=> !active)
    else $error("line still active after its final pixel");

  // A step with no active line yields no pixel.
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == blpg_pkg::CMD_STEP) && !active && !pix_valid) |=> !pix_valid)
    else $error("pixel produced by a step with no active line");

  // A visible pixel never has a negative coordinate.
  a_visible_pos: assert property (@(posedge clk) disable iff (rst)
    (pix_valid && visible) |-> (!pix_x[COORD_BITS-1] && !pix_y[COORD_BITS-1]))
    else $error("visible pixel with a negative coordinate");
`endif

endmodule
`default_nettype wire
